// File: src/hdri_pkg.sv
// ----------------------------------------------------------------------------
// Heading dead-reckoning integrator package
// Command codes, configuration register indexes, reset values and the
// quarter-wave sine table generator.
// ----------------------------------------------------------------------------
package hdri_pkg;

    typedef enum logic [2:0] {
        CMD_SET_POS     = 3'd0,
        CMD_FORWARD     = 3'd1,
        CMD_BACKWARD    = 3'd2,
        CMD_LEFT        = 3'd3,
        CMD_RIGHT       = 3'd4,
        CMD_STEER_LEFT  = 3'd5,
        CMD_STEER_RIGHT = 3'd6
    } t_cmd;

    localparam logic [1:0] CFG_FORWARD_SPEED  = 2'd0;
    localparam logic [1:0] CFG_BACKWARD_SPEED = 2'd1;
    localparam logic [1:0] CFG_STRAFE_SPEED   = 2'd2;
    localparam logic [1:0] CFG_STEER_STEP     = 2'd3;

    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SPEED_W    = 16;
    localparam int STEER_W    = 15;
    localparam int COORD_W    = 32;
    localparam int ANGLE_W    = 16;
    localparam int CMD_W      = 3;
    localparam int TRIG_W     = 16;

    localparam logic [SPEED_W-1:0] SPEED_RESET = 16'd256;
    localparam logic [STEER_W-1:0] STEER_RESET = 15'd512;
    localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;

    localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

    // Q1.15 magnitude of sin(idx * pi/2 / 2^bits), fixed integer Taylor series
    function automatic logic [TRIG_W-1:0] sine_entry(input int unsigned idx,
                                                     input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x    = (64'(idx) * PI_HALF_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 64'sd0) begin
            sum = 64'sd0;
        end
        v = (sum + 64'sd16384) >>> 15;
        if (v > 64'sd32768) begin
            v = 64'sd32768;
        end
        return v[TRIG_W-1:0];
    endfunction

endpackage

// File: src/heading_dead_reckoning_integrator_core.sv
// ----------------------------------------------------------------------------
// Heading dead-reckoning integrator core
// Tracks a Q16.16 position and a 16-bit binary-angle heading, applying one
// command per input word and returning the updated state per output word.
// ----------------------------------------------------------------------------
// One result word per input word, one word per clock sustained unless the
// output stalls. An input register feeds one compute stage (sine/cosine
// table lookup, one 16x16 multiply per axis, round, saturating add) that
// drives the result register and sets the clock. The sine table holds
// 2^SINE_TABLE_BITS + 1 constant entries and needs no fill after reset.
module heading_dead_reckoning_integrator_core
    import hdri_pkg::*;
#(
    parameter int SINE_TABLE_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [95:0]           i_s_tdata,   // load_x, load_y, load_z
    input  logic [CMD_W-1:0]      i_s_tuser,   // command
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [111:0]          o_m_tdata,   // out_x, out_y, out_z, out_heading
    output logic [0:0]            o_m_tuser    // saturated
);

    localparam int TBL_Q = 1 << SINE_TABLE_BITS;
    localparam int IDX_W = SINE_TABLE_BITS + 1;
    localparam int PROD_W = TRIG_W + SPEED_W;
    localparam int STEP_W = PROD_W - 6;
    localparam int SUM_W = COORD_W + 2;

    logic [TRIG_W-1:0] sine_lut [0:TBL_Q];

    for (genvar g = 0; g <= TBL_Q; g++) begin : g_lut
        assign sine_lut[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    logic [SPEED_W-1:0]        r_fwd_speed;
    logic [SPEED_W-1:0]        r_bwd_speed;
    logic [SPEED_W-1:0]        r_strafe_speed;
    logic [STEER_W-1:0]        r_steer_step;

    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic [ANGLE_W-1:0]        r_heading;

    logic                      r_in_vld;
    logic [CMD_W-1:0]          r_in_cmd;
    logic signed [COORD_W-1:0] r_in_x;
    logic signed [COORD_W-1:0] r_in_y;
    logic signed [COORD_W-1:0] r_in_z;

    logic                      r_out_vld;
    logic signed [COORD_W-1:0] r_out_x;
    logic signed [COORD_W-1:0] r_out_y;
    logic signed [COORD_W-1:0] r_out_z;
    logic [ANGLE_W-1:0]        r_out_heading;
    logic                      r_out_sat;

    logic signed [COORD_W-1:0] n_x;
    logic signed [COORD_W-1:0] n_y;
    logic signed [COORD_W-1:0] n_z;
    logic [ANGLE_W-1:0]        n_heading;
    logic                      n_sat;

    logic                      advance;
    logic                      in_fire;

    logic [ANGLE_W-1:0]        ang       [2];
    logic [SINE_TABLE_BITS-1:0] ang_j    [2];
    logic [IDX_W-1:0]          lut_idx   [2];
    logic [TRIG_W-1:0]         trig_mag  [2];
    logic                      trig_neg  [2];

    logic [SPEED_W-1:0]        speed;
    logic                      x_use_cos;
    logic                      x_cmd_neg;
    logic                      z_cmd_neg;
    logic                      is_move;
    logic [TRIG_W-1:0]         x_mag;
    logic [TRIG_W-1:0]         z_mag;
    logic                      x_neg;
    logic                      z_neg;
    logic [PROD_W-1:0]         x_prod;
    logic [PROD_W-1:0]         z_prod;
    logic [STEP_W-1:0]         x_step;
    logic [STEP_W-1:0]         z_step;
    logic signed [COORD_W:0]   x_res;
    logic signed [COORD_W:0]   z_res;

    function automatic logic [COORD_W:0] sat_add(input logic signed [COORD_W-1:0] a,
                                                 input logic [STEP_W-1:0] step,
                                                 input logic neg);
        logic signed [SUM_W-1:0] d;
        logic signed [SUM_W-1:0] s;
        logic                    sat;
        logic [COORD_W-1:0]      v;
        d = $signed({{(SUM_W-STEP_W){1'b0}}, step});
        if (neg) begin
            d = -d;
        end
        s = SUM_W'(a) + d;
        sat = 1'b0;
        v = s[COORD_W-1:0];
        if (s > SUM_W'(32'sh7FFF_FFFF)) begin
            sat = 1'b1;
            v = 32'h7FFF_FFFF;
        end else if (s < SUM_W'(32'sh8000_0000)) begin
            sat = 1'b1;
            v = 32'h8000_0000;
        end
        return {sat, v};
    endfunction

    assign advance    = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_in_vld || advance;
    assign in_fire    = i_s_tvalid && o_s_tready;

    // index 0 is sine, index 1 is cosine
    always_comb begin
        ang[0] = r_heading;
        ang[1] = r_heading + QUARTER_TURN;
        for (int k = 0; k < 2; k++) begin
            ang_j[k]    = ang[k][13 -: SINE_TABLE_BITS];
            lut_idx[k]  = ang[k][14] ? (IDX_W'(TBL_Q) - {1'b0, ang_j[k]})
                                     : {1'b0, ang_j[k]};
            trig_mag[k] = sine_lut[lut_idx[k]];
            trig_neg[k] = ang[k][15];
        end
    end

    always_comb begin
        speed     = '0;
        x_use_cos = 1'b0;
        x_cmd_neg = 1'b0;
        z_cmd_neg = 1'b0;
        is_move   = 1'b0;
        unique case (t_cmd'(r_in_cmd))
            CMD_FORWARD: begin
                speed     = r_fwd_speed;
                x_use_cos = 1'b1;
                z_cmd_neg = 1'b1;
                is_move   = 1'b1;
            end
            CMD_BACKWARD: begin
                speed     = r_bwd_speed;
                x_use_cos = 1'b1;
                x_cmd_neg = 1'b1;
                is_move   = 1'b1;
            end
            CMD_LEFT: begin
                speed     = r_strafe_speed;
                x_cmd_neg = 1'b1;
                z_cmd_neg = 1'b1;
                is_move   = 1'b1;
            end
            CMD_RIGHT: begin
                speed     = r_strafe_speed;
                is_move   = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        x_mag  = x_use_cos ? trig_mag[1] : trig_mag[0];
        z_mag  = x_use_cos ? trig_mag[0] : trig_mag[1];
        x_neg  = (x_use_cos ? trig_neg[1] : trig_neg[0]) ^ x_cmd_neg;
        z_neg  = (x_use_cos ? trig_neg[0] : trig_neg[1]) ^ z_cmd_neg;
        x_prod = x_mag * speed;
        z_prod = z_mag * speed;
        x_step = STEP_W'(({1'b0, x_prod} + (PROD_W+1)'(64)) >> 7);
        z_step = STEP_W'(({1'b0, z_prod} + (PROD_W+1)'(64)) >> 7);
        x_res  = sat_add(r_x, x_step, x_neg);
        z_res  = sat_add(r_z, z_step, z_neg);
    end

    always_comb begin
        n_x       = r_x;
        n_y       = r_y;
        n_z       = r_z;
        n_heading = r_heading;
        n_sat     = 1'b0;
        if (is_move) begin
            n_x   = x_res[COORD_W-1:0];
            n_y   = '0;
            n_z   = z_res[COORD_W-1:0];
            n_sat = x_res[COORD_W] | z_res[COORD_W];
        end else begin
            unique case (t_cmd'(r_in_cmd))
                CMD_SET_POS: begin
                    n_x = r_in_x;
                    n_y = r_in_y;
                    n_z = r_in_z;
                end
                CMD_STEER_LEFT:  n_heading = r_heading + {1'b0, r_steer_step};
                CMD_STEER_RIGHT: n_heading = r_heading - {1'b0, r_steer_step};
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_speed    <= SPEED_RESET;
            r_bwd_speed    <= SPEED_RESET;
            r_strafe_speed <= SPEED_RESET;
            r_steer_step   <= STEER_RESET;
            r_x            <= '0;
            r_y            <= '0;
            r_z            <= '0;
            r_heading      <= '0;
            r_in_vld       <= 1'b0;
            r_out_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_FORWARD_SPEED:  r_fwd_speed    <= i_cfg_wdata;
                    CFG_BACKWARD_SPEED: r_bwd_speed    <= i_cfg_wdata;
                    CFG_STRAFE_SPEED:   r_strafe_speed <= i_cfg_wdata;
                    CFG_STEER_STEP:     r_steer_step   <= i_cfg_wdata[STEER_W-1:0];
                endcase
            end
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (advance && r_in_vld) begin
                r_x       <= n_x;
                r_y       <= n_y;
                r_z       <= n_z;
                r_heading <= n_heading;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_cmd <= i_s_tuser;
            r_in_x   <= i_s_tdata[31:0];
            r_in_y   <= i_s_tdata[63:32];
            r_in_z   <= i_s_tdata[95:64];
        end
        if (advance && r_in_vld) begin
            r_out_x       <= n_x;
            r_out_y       <= n_y;
            r_out_z       <= n_z;
            r_out_heading <= n_heading;
            r_out_sat     <= n_sat;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_heading, r_out_z, r_out_y, r_out_x};
    assign o_m_tuser  = r_out_sat;

endmodule
